// ----- rtl/hgp_pkg.sv -----
// shared constants, codes and types for the hex grid pixel picker
// used by hgp_div, hex_grid_pixel_picker, hgp_checker and the testbench; depends on nothing
package hgp_pkg;

  // grid and table geometry
  localparam int MaxTile   = 64;
  localparam int GridCols  = 16;
  localparam int GridRows  = 16;
  localparam int HexPoints = 6;

  // field and register widths
  localparam int TileW    = 7;
  localparam int SegW     = 6;
  localparam int CoordW   = 12;
  localparam int InsetW   = 6;
  localparam int ColW     = 4;
  localparam int RowW     = 4;
  localparam int YW       = $clog2(MaxTile);
  localparam int RowCntW  = $clog2(GridRows + 1);
  localparam int ColCntW  = $clog2(GridCols);
  localparam int PointW   = $clog2(HexPoints);

  // shared divider widths: magnitudes of dividend and divisor
  localparam int DivW     = 14;
  localparam int DenW     = 8;
  localparam int EdgeW    = DivW + 1;

  // reset values of the configuration registers
  localparam logic [TileW-1:0] TileReset = 7'd24;
  localparam logic [SegW-1:0]  SegReset  = 6'd6;
  localparam int               TileMin   = 2;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_TILE_SIZE    = 1'b0,
    CFG_SEGMENT_SIZE = 1'b1
  } cfg_idx_e;

  // request kinds
  typedef enum logic [0:0] {
    CMD_REBUILD = 1'b0,
    CMD_PICK    = 1'b1
  } cmd_e;

  // divider request and response
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
  } div_rsp_t;

endpackage

// ----- rtl/hgp_div.sv -----
// shared restoring divider, one quotient bit per cycle on unsigned magnitudes
// depends on hgp_pkg for widths and the request and response types
module hgp_div
  import hgp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CntW = $clog2(DivW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] acc_q, acc_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   trial;
  logic            take;

  assign trial = {rem_q, acc_q[DivW-1]};
  assign take  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivW - 1);
      acc_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      // shift in the next dividend bit, shift out one quotient bit
      rem_d = take ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      acc_d = {acc_q[DivW-2:0], take};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = acc_q;

endmodule

// ----- rtl/hex_grid_pixel_picker.sv -----
// sequence from the accepting edge to a valid result:
// rebuild gives each straddling hexagon edge a setup state and a divide on the shared divider,
// then walks one x per cycle across each scanline
// pick divides for the row estimate when y is positive, then per candidate row sets up the row
// and tests up to 16 columns at one per cycle; one request at a time, the result sits in an output
// register so the next request may enter before it is taken
// reset: tile size 24, segment size 6, inset table holds garbage until the first rebuild
module hex_grid_pixel_picker
  import hgp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pixel_x [11:0], pixel_y [23:12]
  input  logic [0:0]  s_axis_tuser,   // command [0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // tile_col [3:0], tile_row [7:4]
  output logic [0:0]  m_axis_tuser,   // found [0]
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  cfg_idx_e    cfg_index_i,
  input  logic [6:0]  cfg_data_i
);

  // sequencer states
  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_EST      = 8'b0000_0010,  // waiting for the row estimate divide
    ST_EDGE     = 8'b0000_0100,  // set up one hexagon edge crossing
    ST_EDGE_DIV = 8'b0000_1000,  // waiting for the edge crossing divide
    ST_XSCAN    = 8'b0001_0000,  // walk x across one scanline
    ST_ROW      = 8'b0010_0000,  // set up one candidate row
    ST_COL      = 8'b0100_0000,  // test one column per cycle
    ST_DONE     = 8'b1000_0000   // hand result to the output register
  } state_e;

  localparam int TxW  = $clog2(GridCols * MaxTile + 1);
  localparam int CmpW = CoordW + 1;

  state_e state_q, state_d;

  // configuration
  logic [TileW-1:0] tile_q;
  logic [SegW-1:0]  seg_q;

  // request payload
  logic signed [CoordW-1:0] px_q, px_d;
  logic signed [CoordW-1:0] py_q, py_d;

  // rebuild counters and edge results
  logic [YW-1:0]     y_q, y_d;
  logic [YW-1:0]     x_q, x_d;
  logic [PointW-1:0] i_q, i_d;
  logic [HexPoints-1:0]   vld_q, vld_d;
  logic                   neg_q, neg_d;
  logic signed [8:0]      base_q, base_d;
  logic signed [EdgeW-1:0] edge_q [HexPoints];
  logic                    edge_we;
  logic signed [EdgeW-1:0] edge_val;

  // pick counters
  logic [RowCntW-1:0] r_q, r_d;
  logic [RowCntW-1:0] r_end_q, r_end_d;
  logic [ColCntW-1:0] col_q, col_d;
  logic [TxW-1:0]     tx_q, tx_d;
  logic               hit_q, hit_d;

  // output register
  logic            m_valid_q, m_valid_d;
  logic            m_found_q, m_found_d;
  logic [ColW-1:0] m_col_q, m_col_d;
  logic [RowW-1:0] m_row_q, m_row_d;

  // inset table
  logic [InsetW-1:0] inset_mem [MaxTile];
  logic [InsetW-1:0] inset_rd_q;
  logic              mem_we, mem_re;
  logic [InsetW-1:0] mem_wdata;
  logic [YW-1:0]     mem_raddr;

  // shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  hgp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // effective tile size, half tile and row pitch
  logic [TileW-1:0]      t_eff;
  logic [TileW-2:0]      half_t;
  logic signed [TileW:0] pitch_raw;
  logic [TileW-1:0]      pitch;
  logic [YW-1:0]         t_last;

  always_comb begin
    if (tile_q < TileW'(TileMin)) t_eff = TileW'(TileMin);
    else if (tile_q > TileW'(MaxTile)) t_eff = TileW'(MaxTile);
    else t_eff = tile_q;
  end

  assign half_t    = t_eff[TileW-1:1];
  assign pitch_raw = signed'({1'b0, t_eff}) - signed'((TileW+1)'(seg_q));
  assign pitch     = (pitch_raw < 1) ? TileW'(1) : pitch_raw[TileW-1:0];
  assign t_last    = YW'(t_eff - TileW'(1));

  // hexagon corners: x and y of point k
  function automatic logic signed [8:0] hex_x(input logic [PointW-1:0] k,
                                              input logic [TileW-1:0] t,
                                              input logic [TileW-2:0] h);
    logic signed [8:0] v;
    case (k) inside
      3'd0, 3'd3: v = signed'(9'(h));
      3'd1, 3'd2: v = '0;
      default:    v = signed'(9'(t));
    endcase
    return v;
  endfunction

  function automatic logic signed [8:0] hex_y(input logic [PointW-1:0] k,
                                              input logic [TileW-1:0] t,
                                              input logic [SegW-1:0] s);
    logic signed [8:0] v;
    case (k) inside
      3'd1, 3'd5: v = signed'(9'(s));
      3'd2, 3'd4: v = signed'(9'(t)) - signed'(9'(s));
      3'd3:       v = signed'(9'(t));
      default:    v = '0;
    endcase
    return v;
  endfunction

  // edge setup: crossing of the edge from point j to point i at scanline y
  logic [PointW-1:0]  j_idx;
  logic signed [8:0]  hx_i, hx_j, hy_i, hy_j, y_s;
  logic signed [8:0]  dx, dyn, den;
  logic signed [17:0] prod, prod_abs;
  logic signed [8:0]  den_abs;
  logic               straddle;

  assign j_idx    = (i_q == '0) ? PointW'(HexPoints - 1) : i_q - PointW'(1);
  assign hx_i     = hex_x(i_q, t_eff, half_t);
  assign hx_j     = hex_x(j_idx, t_eff, half_t);
  assign hy_i     = hex_y(i_q, t_eff, seg_q);
  assign hy_j     = hex_y(j_idx, t_eff, seg_q);
  assign y_s      = signed'(9'(y_q));
  assign straddle = (hy_i > y_s) != (hy_j > y_s);
  assign dx       = hx_j - hx_i;
  assign dyn      = y_s - hy_i;
  assign den      = hy_j - hy_i;
  assign prod     = dx * dyn;
  assign prod_abs = prod[17] ? -prod : prod;
  assign den_abs  = den[8] ? -den : den;

  // truncating signed quotient plus the edge start x
  logic signed [EdgeW-1:0] q_ext, q_s;
  assign q_ext    = signed'({1'b0, div_rsp.quot});
  assign q_s      = neg_q ? -q_ext : q_ext;
  assign edge_val = q_s + EdgeW'(base_q);

  // crossing-number parity at the current x
  logic signed [EdgeW-1:0] x_s;
  logic [HexPoints-1:0]    lt_vec;
  logic                    inside_hex;

  assign x_s = signed'(EdgeW'(x_q));
  always_comb begin
    for (int k = 0; k < HexPoints; k++) begin
      lt_vec[k] = x_s < edge_q[k];
    end
  end
  assign inside_hex = ^(vld_q & lt_vec);

  // incoming request fields
  logic signed [CoordW-1:0] px_in, py_in;
  logic                     py_pos;
  logic                     in_acc;

  assign px_in  = signed'(s_axis_tdata[CoordW-1:0]);
  assign py_in  = signed'(s_axis_tdata[2*CoordW-1:CoordW]);
  assign py_pos = !py_in[CoordW-1] && (py_in != '0);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // row window from the estimate: rows max(0,q-3) up to min(rows,q+1)-1
  logic [DivW-1:0] quot;
  logic            est_miss;
  logic [RowCntW-1:0] est_lo, est_hi;

  assign quot     = div_rsp.quot;
  assign est_miss = quot >= DivW'(GridRows + 3);
  assign est_lo   = (quot < DivW'(3)) ? '0 : RowCntW'(quot - DivW'(3));
  assign est_hi   = (quot >= DivW'(GridRows)) ? RowCntW'(GridRows)
                                              : RowCntW'(quot + DivW'(1));

  // row setup: scanline inside the tile
  logic [10:0]            ty;
  logic signed [CmpW-1:0] py_ext, yi;
  logic                   row_ok;

  assign ty     = 11'(r_q[RowW-1:0]) * 11'(pitch);
  assign py_ext = CmpW'(py_q);
  assign yi     = py_ext - signed'(CmpW'(ty));
  assign row_ok = !yi[CmpW-1] && (yi < signed'(CmpW'(t_eff)));

  // column test against the inset span
  logic signed [CmpW-1:0] tx_s, ins_s, t_s, lo_x, hi_x, px_ext;
  logic                   col_hit;

  assign tx_s    = signed'(CmpW'(tx_q));
  assign ins_s   = signed'(CmpW'(inset_rd_q));
  assign t_s     = signed'(CmpW'(t_eff));
  assign px_ext  = CmpW'(px_q);
  assign lo_x    = tx_s + ins_s;
  assign hi_x    = tx_s + t_s - ins_s;
  assign col_hit = (px_ext >= lo_x) && (px_ext <= hi_x);

  // handshakes
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  // sequencer
  always_comb begin
    state_d   = state_q;
    px_d      = px_q;
    py_d      = py_q;
    y_d       = y_q;
    x_d       = x_q;
    i_d       = i_q;
    vld_d     = vld_q;
    neg_d     = neg_q;
    base_d    = base_q;
    r_d       = r_q;
    r_end_d   = r_end_q;
    col_d     = col_q;
    tx_d      = tx_q;
    hit_d     = hit_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_found_d = m_found_q;
    m_col_d   = m_col_q;
    m_row_d   = m_row_q;
    edge_we   = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = half_t;
    mem_re    = 1'b0;
    mem_raddr = yi[YW-1:0];

    div_req.start    = 1'b0;
    div_req.dividend = DivW'(py_in[CoordW-2:0]) + DivW'(pitch) - DivW'(1);
    div_req.divisor  = DenW'(pitch);

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          hit_d = 1'b0;
          px_d  = px_in;
          py_d  = py_in;
          if (cmd_e'(s_axis_tuser[0]) == CMD_REBUILD) begin
            y_d     = '0;
            i_d     = '0;
            state_d = ST_EDGE;
          end else if (py_pos) begin
            // ceil(y / pitch) via one divide
            div_req.start = 1'b1;
            state_d       = ST_EST;
          end else begin
            // estimate is -1: only row 0 is a candidate
            r_d     = '0;
            r_end_d = RowCntW'(1);
            state_d = ST_ROW;
          end
        end
      end

      ST_EST: begin
        if (div_rsp.done) begin
          r_d     = est_lo;
          r_end_d = est_hi;
          state_d = est_miss ? ST_DONE : ST_ROW;
        end
      end

      ST_EDGE: begin
        div_req.dividend = prod_abs[DivW-1:0];
        div_req.divisor  = den_abs[DenW-1:0];
        neg_d            = prod[17] ^ den[8];
        base_d           = hx_i;
        vld_d[i_q]       = straddle;
        if (straddle) begin
          div_req.start = 1'b1;
          state_d       = ST_EDGE_DIV;
        end else if (i_q == PointW'(HexPoints - 1)) begin
          x_d     = '0;
          state_d = ST_XSCAN;
        end else begin
          i_d = i_q + PointW'(1);
        end
      end

      ST_EDGE_DIV: begin
        if (div_rsp.done) begin
          edge_we = 1'b1;
          if (i_q == PointW'(HexPoints - 1)) begin
            x_d     = '0;
            state_d = ST_XSCAN;
          end else begin
            i_d     = i_q + PointW'(1);
            state_d = ST_EDGE;
          end
        end
      end

      ST_XSCAN: begin
        // first x inside the hexagon, else half a tile
        if (inside_hex || x_q == t_last) begin
          mem_we    = 1'b1;
          mem_wdata = inside_hex ? InsetW'(x_q) : InsetW'(half_t);
          if (y_q == t_last) begin
            state_d = ST_DONE;
          end else begin
            y_d     = y_q + YW'(1);
            i_d     = '0;
            state_d = ST_EDGE;
          end
        end else begin
          x_d = x_q + YW'(1);
        end
      end

      ST_ROW: begin
        if (r_q == r_end_q) begin
          state_d = ST_DONE;
        end else if (row_ok) begin
          // even rows are shifted right by half a tile
          mem_re  = 1'b1;
          col_d   = '0;
          tx_d    = r_q[0] ? '0 : TxW'(half_t);
          state_d = ST_COL;
        end else begin
          r_d = r_q + RowCntW'(1);
        end
      end

      ST_COL: begin
        if (col_hit) begin
          hit_d   = 1'b1;
          state_d = ST_DONE;
        end else if (col_q == ColCntW'(GridCols - 1)) begin
          r_d     = r_q + RowCntW'(1);
          state_d = ST_ROW;
        end else begin
          col_d = col_q + ColCntW'(1);
          tx_d  = tx_q + TxW'(t_eff);
        end
      end

      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_found_d = hit_q;
          m_col_d   = hit_q ? ColW'(col_q) : '0;
          m_row_d   = hit_q ? r_q[RowW-1:0] : '0;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tile_q    <= TileReset;
      seg_q     <= SegReset;
      y_q       <= '0;
      x_q       <= '0;
      i_q       <= '0;
      vld_q     <= '0;
      r_q       <= '0;
      r_end_q   <= '0;
      col_q     <= '0;
      hit_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      y_q       <= y_d;
      x_q       <= x_d;
      i_q       <= i_d;
      vld_q     <= vld_d;
      r_q       <= r_d;
      r_end_q   <= r_end_d;
      col_q     <= col_d;
      hit_q     <= hit_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_TILE_SIZE:    tile_q <= cfg_data_i;
          CFG_SEGMENT_SIZE: seg_q  <= cfg_data_i[SegW-1:0];
          default:          ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    px_q      <= px_d;
    py_q      <= py_d;
    neg_q     <= neg_d;
    base_q    <= base_d;
    tx_q      <= tx_d;
    m_found_q <= m_found_d;
    m_col_q   <= m_col_d;
    m_row_q   <= m_row_d;
    if (edge_we) edge_q[i_q] <= edge_val;
  end

  // inset table, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) inset_mem[y_q] <= mem_wdata;
    if (mem_re) inset_rd_q <= inset_mem[mem_raddr];
  end

  // result stream
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_row_q, m_col_q};
  assign m_axis_tuser  = m_found_q;

`ifndef SYNTHESIS
  // a miss or a rebuild always reports tile zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_found_q |-> m_col_q == '0 && m_row_q == '0)
    else $error("miss result carries a nonzero tile");

  // inset writes stay inside the current tile height
  a_inset_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> y_q <= t_last)
    else $error("inset write beyond tile height");

  // column scan only runs on a row inside the window
  a_col_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COL |-> r_q < r_end_q && r_end_q <= RowCntW'(GridRows))
    else $error("column scan outside the row window");

  // an accepted request closes the input until its result is staged
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("request accepted while busy");
`endif

endmodule

// ----- test/hgp_checker.sv -----
// hgp_checker: watches the request, result and config channels of the hex grid pixel picker
// keeps its own copy of the tile geometry and inset table and checks every result in order
// depends on hgp_pkg for widths, register indexes and request kinds
module hgp_checker
  import hgp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pixel_x [11:0], pixel_y [23:12]
  input  logic [0:0]  s_axis_tuser,   // command [0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // tile_col [3:0], tile_row [7:4]
  input  logic [0:0]  m_axis_tuser,   // found [0]
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  cfg_idx_e    cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            found;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
  } tile_hit_t;

  logic [TileW-1:0]  tile_q = TileReset;
  logic [SegW-1:0]   seg_q  = SegReset;
  logic [InsetW-1:0] inset_tbl [MaxTile];
  tile_hit_t         hits_due [$];
  int                errors = 0;

  initial errors_o = 0;
  initial pending_o = 0;

  task automatic report_mismatch(string what, int got, int want);
    if (errors < 50) $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what,
                              got, want);
    errors++;
  endtask

  function automatic int clamp_tile(logic [TileW-1:0] v);
    int t;
    t = v;
    if (t < TileMin) t = TileMin;
    if (t > MaxTile) t = MaxTile;
    return t;
  endfunction

  // crossing-number test against the six corners, truncating division
  function automatic bit hex_contains(int t, int s, int px, int py);
    int hx [HexPoints];
    int hy [HexPoints];
    int i, j, cross_x;
    bit in_hex;
    hx[0] = t / 2; hy[0] = 0;
    hx[1] = 0;     hy[1] = s;
    hx[2] = 0;     hy[2] = t - s;
    hx[3] = t / 2; hy[3] = t;
    hx[4] = t;     hy[4] = t - s;
    hx[5] = t;     hy[5] = s;
    in_hex = 1'b0;
    j = HexPoints - 1;
    for (i = 0; i < HexPoints; i++) begin
      if ((hy[i] > py) != (hy[j] > py)) begin
        cross_x = (hx[j] - hx[i]) * (py - hy[i]) / (hy[j] - hy[i]) + hx[i];
        if (px < cross_x) in_hex = !in_hex;
      end
      j = i;
    end
    return in_hex;
  endfunction

  // first inside x per scanline, half a tile when the scanline is empty
  function automatic void fill_insets();
    int t, s, x, y, first;
    bit hit;
    t = clamp_tile(tile_q);
    s = seg_q;
    for (y = 0; y < t; y++) begin
      first = t / 2;
      hit = 1'b0;
      for (x = 0; x < t; x++) begin
        if (!hit && hex_contains(t, s, x, y)) begin
          first = x;
          hit = 1'b1;
        end
      end
      inset_tbl[y] = first[InsetW-1:0];
    end
  endfunction

  function automatic tile_hit_t locate_tile(int px, int py);
    tile_hit_t hit;
    int t, pitch, est, lo, hi, r, c, yi, ins, tx;
    t = clamp_tile(tile_q);
    pitch = t - int'(seg_q);
    if (pitch < 1) pitch = 1;
    est = (py <= 0) ? -1 : (py + pitch - 1) / pitch - 1;
    lo = est - 2;
    if (lo < 0) lo = 0;
    hi = est + 2;
    if (hi > GridRows) hi = GridRows;
    hit = '0;
    for (r = lo; r < hi && !hit.found; r++) begin
      yi = py - r * pitch;
      if (yi >= 0 && yi < t) begin
        ins = inset_tbl[yi];
        for (c = 0; c < GridCols && !hit.found; c++) begin
          // even rows sit half a tile to the right
          tx = c * t + ((r % 2 == 0) ? t / 2 : 0);
          if (px >= tx + ins && px <= tx + t - ins) begin
            hit.found = 1'b1;
            hit.col   = c[ColW-1:0];
            hit.row   = r[RowW-1:0];
          end
        end
      end
    end
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    tile_hit_t want;
    if (!rst_ni) begin
      tile_q = TileReset;
      seg_q  = SegReset;
      hits_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TILE_SIZE:    tile_q = cfg_data_i;
          CFG_SEGMENT_SIZE: seg_q  = cfg_data_i[SegW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == CMD_REBUILD) begin
          fill_insets();
          hits_due.push_back('0);
        end else begin
          hits_due.push_back(locate_tile($signed(s_axis_tdata[11:0]),
                                         $signed(s_axis_tdata[23:12])));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (hits_due.size() == 0) begin
          report_mismatch("result with nothing due", m_axis_tdata, 0);
        end else begin
          want = hits_due.pop_front();
          if (m_axis_tuser[0] !== want.found) report_mismatch("found", m_axis_tuser[0], want.found);
          if (m_axis_tdata[3:0] !== want.col) report_mismatch("tile_col", m_axis_tdata[3:0], want.col);
          if (m_axis_tdata[7:4] !== want.row) report_mismatch("tile_row", m_axis_tdata[7:4], want.row);
        end
      end
    end
    pending_o <= hits_due.size();
    errors_o  <= errors;
  end

endmodule

// ----- test/tb_hex_grid_pixel_picker.sv -----
// tb_hex_grid_pixel_picker: stimulus and verdict for the hex grid pixel picker
// directed geometry corners, then random config phases with bursty requests and a stalling sink
// depends on hgp_pkg, hgp_checker and the hex_grid_pixel_picker rtl
module tb_hex_grid_pixel_picker;
  timeunit 1ns;
  timeprecision 1ps;
  import hgp_pkg::*;

  // run shape
  localparam int CycleLimit    = 3_000_000;
  localparam int RandomPhases  = 10;
  localparam int ItemsPerPhase = 125;
  localparam int HoldOffCycles = 400;
  localparam int DrainCycles   = 200;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // pixel_x [11:0], pixel_y [23:12]
  logic [0:0]  s_axis_tuser  = '0;   // command [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // tile_col [3:0], tile_row [7:4]
  logic [0:0]  m_axis_tuser;         // found [0]
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  cfg_idx_e    cfg_index_i   = CFG_TILE_SIZE;
  logic [6:0]  cfg_data_i    = '0;

  int mismatches;
  int results_due;

  // stimulus-side view of the registers, used to aim picks and keep the table valid
  logic [TileW-1:0] tile_reg = TileReset;
  logic [SegW-1:0]  seg_reg  = SegReset;
  // rows of the inset table written so far (rebuild writes rows 0..tile-1)
  int  built_span    = 0;
  int  burst_left    = 0;
  bit  steady_sender = 1'b0;
  bit  long_hold_req = 1'b0;

  hex_grid_pixel_picker u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  hgp_checker u_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .errors_o    (mismatches),
    .pending_o   (results_due)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // tile size as the block sees it
  function automatic int sat_tile(logic [TileW-1:0] v);
    int t;
    t = v;
    if (t < TileMin) t = TileMin;
    if (t > MaxTile) t = MaxTile;
    return t;
  endfunction

  // one request; bursts of random length, random gaps between bursts
  // tvalid stays high after acceptance so back-to-back requests need no extra step
  task automatic offer(cmd_e cmd, logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady_sender ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == CMD_REBUILD && sat_tile(tile_reg) > built_span) built_span = sat_tile(tile_reg);
  endtask

  task automatic pick_at(int x, int y);
    offer(CMD_PICK, x[CoordW-1:0], y[CoordW-1:0]);
  endtask

  // pixel fields of a rebuild are don't-care, so fill them with noise
  task automatic rebuild_table();
    offer(CMD_REBUILD, CoordW'($urandom), CoordW'($urandom));
  endtask

  // pick near a random tile of the grid, a couple of pixels over its edges
  task automatic aimed_pick();
    int t, pitch, r, c, x, y;
    t = sat_tile(tile_reg);
    pitch = t - int'(seg_reg);
    if (pitch < 1) pitch = 1;
    r = $urandom_range(0, GridRows - 1);
    c = $urandom_range(0, GridCols - 1);
    x = c * t + ((r % 2 == 0) ? t / 2 : 0) + $urandom_range(0, t + 4) - 2;
    y = r * pitch + $urandom_range(0, t + 1) - 1;
    pick_at(x, y);
  endtask

  // drop tvalid and wait until every result is out and the block is quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [6:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // register writes only happen with the block idle
  task automatic reconfigure(bit do_tile, logic [6:0] tile_val, bit do_seg, logic [6:0] seg_val);
    settle();
    if (do_tile) begin
      write_reg(CFG_TILE_SIZE, tile_val);
      tile_reg = tile_val;
    end
    if (do_seg) begin
      write_reg(CFG_SEGMENT_SIZE, seg_val);
      seg_reg = seg_val[SegW-1:0];
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(bit with_hold);
    logic [6:0] tv, sv;
    bit wt, ws;
    int n;
    // mostly small tiles, sometimes saturating ones at either end
    case ($urandom_range(0, 7))
      0:       tv = 7'($urandom_range(0, 1));
      1:       tv = 7'($urandom_range(64, 127));
      2:       tv = 7'($urandom_range(25, 63));
      default: tv = 7'($urandom_range(2, 24));
    endcase
    case ($urandom_range(0, 5))
      0:       sv = '0;
      1:       sv = 7'($urandom_range(0, 127));
      default: sv = 7'($urandom_range(0, sat_tile(tv) / 2));
    endcase
    // leaving a register unwritten keeps the table stale against the other
    wt = ($urandom_range(0, 4) != 0);
    ws = ($urandom_range(0, 4) != 0);
    reconfigure(wt, tv, ws, sv);
    // the sink holds off while this phase keeps offering requests
    if (with_hold) long_hold_req = 1'b1;
    steady_sender = ($urandom_range(0, 3) == 0);
    for (n = 0; n < ItemsPerPhase; n++) begin
      if (n == 0 && (sat_tile(tile_reg) > built_span || $urandom_range(0, 1) == 1)) begin
        // a larger tile would read rows never written, so the table is rebuilt first
        rebuild_table();
      end else if ($urandom_range(0, (sat_tile(tile_reg) > 32) ? 49 : 15) == 0) begin
        rebuild_table();
      end else if ($urandom_range(0, 4) == 0) begin
        pick_at($urandom_range(0, 4095), $urandom_range(0, 4095));
      end else begin
        aimed_pick();
      end
    end
  endtask

  // result sink: ready pattern switches between randomly chosen modes,
  // plus one long hold-off so the block backs up into its request side
  initial begin : result_sink
    int hold_left = 0;
    int mode_left = 0;
    int mode      = 0;
    bit hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !hold_done) begin
        hold_left = HoldOffCycles;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // cycle counter, ends a hung run
  initial begin : watchdog
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int ph;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset geometry: tile 24, segment 6, row pitch 18
    rebuild_table();
    pick_at(-2048, -2048);    // extreme corner, y not positive
    pick_at(2047, 2047);      // far corner, miss
    pick_at(0, 0);
    pick_at(24, 12);          // middle of tile (0,0)
    pick_at(12, 30);          // odd row, no shift
    pick_at(372, 282);        // last column of the last row
    pick_at(-1, 1);
    pick_at(395, 12);         // right tip of the last tile in row 0

    // tile below minimum saturates to 2, flat hexagon, table still from tile 24
    reconfigure(1'b1, 7'd0, 1'b1, 7'd0);
    pick_at(1, 1);
    pick_at(3, 2);
    rebuild_table();
    pick_at(1, 0);

    // tile above maximum saturates to 64, table must grow first
    reconfigure(1'b1, 7'h7f, 1'b1, 7'h20);
    rebuild_table();
    pick_at(48, 16);
    pick_at(2047, 1000);
    pick_at(1000, 2047);

    // segment beyond the tile: row pitch clamps to one, upper data bit dropped
    reconfigure(1'b1, 7'd20, 1'b1, 7'h7f);
    pick_at(10, 5);
    pick_at(25, 3);
    pick_at(1500, 15);
    rebuild_table();
    pick_at(10, 10);
    pick_at(-100, 100);

    for (ph = 0; ph < RandomPhases; ph++) begin
      random_phase(ph == 2);
    end

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
